// ===== sv/rlcm_pkg.sv =====
// shared types and constants for the run list cluster mapper
package rlcm_pkg;

	localparam int LCN_W   = 64;
	localparam int BYTE_W  = 8;
	localparam int SIZE_W  = 4;
	localparam int INDEX_W = 3;

	localparam logic [SIZE_W-1:0] MAX_FIELD_BYTES = 4'd8;
	localparam logic [SIZE_W-1:0] NIBBLE_MASK     = 4'hF;

	localparam logic REQ_START = 1'b0;
	localparam logic REQ_BYTE  = 1'b1;

	typedef enum logic [3:0] {
		PH_IDLE   = 4'b0001,
		PH_HEADER = 4'b0010,
		PH_COUNT  = 4'b0100,
		PH_OFFSET = 4'b1000
	} phase_t;

	typedef enum logic [1:0] {
		ST_FOUND     = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_MALFORMED = 2'd2
	} status_t;

	typedef struct packed {
		logic             valid;
		status_t          status;
		logic [LCN_W-1:0] lcn;
	} result_t;

endpackage

// ===== sv/rlcm_if.sv =====
// request and result channel interfaces
interface rlcm_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [63:0] target_vcn;
	logic [7:0]  run_byte;
	logic        last_byte;

	modport source (output valid, output req_type, output target_vcn, output run_byte,
		output last_byte, input ready);
	modport sink (input valid, input req_type, input target_vcn, input run_byte,
		input last_byte, output ready);
endinterface

interface rlcm_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [63:0] lcn;

	modport source (output valid, output status, output lcn, input ready);
	modport sink (input valid, input status, input lcn, output ready);
endinterface

// ===== sv/run_list_cluster_mapper.sv =====
// Maps a virtual cluster number to a logical cluster number by walking a data run list
// that streams in one byte per transfer. A start transfer latches the target, and the
// answer (found, not found or malformed) appears in the result register on the cycle
// after the byte that decides it. The block takes one transfer per clock whenever the
// result register is empty or is being read, so the rate is one byte per cycle, set by
// the single pass from the walker state through the lcn add and compare into the result
// register.
module run_list_cluster_mapper #(
	parameter int CLUSTER_BITS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	rlcm_req_if.sink   req,
	rlcm_res_if.source res
);
	import rlcm_pkg::*;

	result_t result;
	logic    take;
	logic    fire;

	assign req.ready = take;
	assign fire      = req.valid && take;

	rlcm_run_walker #(
		.CLUSTER_BITS(CLUSTER_BITS)
	) u_walker (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.req_type  (req.req_type),
		.target_vcn(req.target_vcn),
		.run_byte  (req.run_byte),
		.last_byte (req.last_byte),
		.result    (result)
	);

	rlcm_result_reg u_result (
		.clk   (clk),
		.arst_n(arst_n),
		.result(result),
		.take  (take),
		.res   (res)
	);

	// a new result only follows a run byte transfer
	a_rise_after_byte: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res.valid) |-> $past(req.valid && req.ready && req.req_type == REQ_BYTE))
		else $error("result appeared without a run byte transfer");

	a_lcn_zero_unless_found: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.status != ST_FOUND |-> res.lcn == '0)
		else $error("lcn nonzero on a not found or malformed result");

	a_lcn_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.lcn >> CLUSTER_BITS) == '0)
		else $error("lcn exceeds the cluster width");

endmodule

// ===== sv/rlcm_run_walker.sv =====
// run list walker: header decode, field assembly, lcn update and lookup compare
module rlcm_run_walker #(
	parameter int CLUSTER_BITS = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     fire,
	input  logic                     req_type,
	input  logic [63:0]              target_vcn,
	input  logic [7:0]               run_byte,
	input  logic                     last_byte,
	output rlcm_pkg::result_t        result
);
	import rlcm_pkg::*;

	phase_t                    phase_q, phase_n;
	logic [SIZE_W-1:0]         bytes_left_q, bytes_left_n;
	logic [INDEX_W-1:0]        byte_index_q, byte_index_n;
	logic [SIZE_W-1:0]         offset_size_q, offset_size_n;
	logic [CLUSTER_BITS-1:0]   count_acc_q, count_acc_n;
	logic [CLUSTER_BITS-1:0]   offset_acc_q, offset_acc_n;
	logic [CLUSTER_BITS-1:0]   running_lcn_q, running_lcn_n;
	logic [CLUSTER_BITS-1:0]   remaining_vcn_q, remaining_vcn_n;

	logic [SIZE_W-1:0]         count_size, offset_size;
	logic [63:0]               byte_sh;
	logic [CLUSTER_BITS-1:0]   count_ins, offset_ins;
	logic [CLUSTER_BITS-1:0]   cnt_src, off_src;
	logic [63:0]               off64, off_ext, low_mask;
	logic [5:0]                width_bits, sign_pos;
	logic [CLUSTER_BITS-1:0]   new_lcn, found_lcn;
	logic                      found, finish;

	assign count_size  = run_byte[3:0];
	assign offset_size = run_byte[7:4];
	assign byte_sh     = 64'(run_byte) << {byte_index_q, 3'b000};
	assign count_ins   = count_acc_q | byte_sh[CLUSTER_BITS-1:0];
	assign offset_ins  = offset_acc_q | byte_sh[CLUSTER_BITS-1:0];

	always_comb begin
		cnt_src = '0;
		off_src = '0;
		case (phase_q)
			PH_COUNT: begin
				cnt_src = count_ins;
			end
			PH_OFFSET: begin
				cnt_src = count_acc_q;
				off_src = offset_ins;
			end
			default: begin
				cnt_src = '0;
				off_src = '0;
			end
		endcase
	end

	// sign extension of a short offset field
	assign off64      = 64'(off_src);
	assign width_bits = {offset_size_q[2:0], 3'b000};
	assign sign_pos   = width_bits - 6'd1;
	assign low_mask   = (64'd1 << width_bits) - 64'd1;

	always_comb begin
		case (offset_size_q) inside
			4'd0: begin
				off_ext = '0;
			end
			[4'd1:4'd7]: begin
				off_ext = off64[sign_pos] ? (off64 | ~low_mask) : off64;
			end
			default: begin
				off_ext = off64;
			end
		endcase
	end

	assign new_lcn   = running_lcn_q + off_ext[CLUSTER_BITS-1:0];
	assign found     = remaining_vcn_q < cnt_src;
	assign found_lcn = new_lcn + remaining_vcn_q;

	always_comb begin
		phase_n         = phase_q;
		bytes_left_n    = bytes_left_q;
		byte_index_n    = byte_index_q;
		offset_size_n   = offset_size_q;
		count_acc_n     = count_acc_q;
		offset_acc_n    = offset_acc_q;
		running_lcn_n   = running_lcn_q;
		remaining_vcn_n = remaining_vcn_q;
		result          = '{valid: 1'b0, status: ST_NOT_FOUND, lcn: '0};
		finish          = 1'b0;

		if (fire) begin
			if (req_type == REQ_START) begin
				remaining_vcn_n = target_vcn[CLUSTER_BITS-1:0];
				running_lcn_n   = '0;
				count_acc_n     = '0;
				offset_acc_n    = '0;
				bytes_left_n    = '0;
				byte_index_n    = '0;
				offset_size_n   = '0;
				phase_n         = PH_HEADER;
			end else if (phase_q != PH_IDLE) begin
				case (phase_q)
					PH_HEADER: begin
						if (run_byte == '0) begin
							result  = '{valid: 1'b1, status: ST_NOT_FOUND, lcn: '0};
							phase_n = PH_IDLE;
						end else if (count_size > MAX_FIELD_BYTES ||
								offset_size > MAX_FIELD_BYTES) begin
							result  = '{valid: 1'b1, status: ST_MALFORMED, lcn: '0};
							phase_n = PH_IDLE;
						end else begin
							offset_size_n = offset_size;
							count_acc_n   = '0;
							offset_acc_n  = '0;
							byte_index_n  = '0;
							if (count_size != '0) begin
								phase_n      = PH_COUNT;
								bytes_left_n = count_size;
							end else if (offset_size != '0) begin
								phase_n      = PH_OFFSET;
								bytes_left_n = offset_size;
							end else begin
								finish = 1'b1;
							end
						end
					end
					PH_COUNT: begin
						count_acc_n  = count_ins;
						byte_index_n = byte_index_q + 3'd1;
						bytes_left_n = bytes_left_q - 4'd1;
						if (bytes_left_q == 4'd1) begin
							byte_index_n = '0;
							if (offset_size_q != '0) begin
								phase_n      = PH_OFFSET;
								bytes_left_n = offset_size_q & NIBBLE_MASK;
							end else begin
								finish = 1'b1;
							end
						end
					end
					PH_OFFSET: begin
						offset_acc_n = offset_ins;
						byte_index_n = byte_index_q + 3'd1;
						bytes_left_n = bytes_left_q - 4'd1;
						if (bytes_left_q == 4'd1) begin
							byte_index_n = '0;
							finish       = 1'b1;
						end
					end
					default: begin
						phase_n = PH_IDLE;
					end
				endcase

				if (finish) begin
					running_lcn_n = new_lcn;
					if (found) begin
						result  = '{valid: 1'b1, status: ST_FOUND, lcn: 64'(found_lcn)};
						phase_n = PH_IDLE;
					end else begin
						remaining_vcn_n = remaining_vcn_q - cnt_src;
						phase_n         = PH_HEADER;
					end
				end

				// list end without an answer
				if (last_byte && phase_n != PH_IDLE) begin
					result  = '{valid: 1'b1, status: ST_NOT_FOUND, lcn: '0};
					phase_n = PH_IDLE;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_IDLE;
			bytes_left_q    <= '0;
			byte_index_q    <= '0;
			offset_size_q   <= '0;
			count_acc_q     <= '0;
			offset_acc_q    <= '0;
			running_lcn_q   <= '0;
			remaining_vcn_q <= '0;
		end else begin
			phase_q         <= phase_n;
			bytes_left_q    <= bytes_left_n;
			byte_index_q    <= byte_index_n;
			offset_size_q   <= offset_size_n;
			count_acc_q     <= count_acc_n;
			offset_acc_q    <= offset_acc_n;
			running_lcn_q   <= running_lcn_n;
			remaining_vcn_q <= remaining_vcn_n;
		end
	end

endmodule

// ===== sv/rlcm_result_reg.sv =====
// result register between the walker and the result channel
module rlcm_result_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  rlcm_pkg::result_t result,
	output logic              take,
	rlcm_res_if.source        res
);
	import rlcm_pkg::*;

	logic        valid_q;
	status_t     status_q;
	logic [63:0] lcn_q;

	assign take = !valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= result.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && result.valid) begin
			status_q <= result.status;
			lcn_q    <= result.lcn;
		end
	end

	assign res.valid  = valid_q;
	assign res.status = 2'(status_q);
	assign res.lcn    = lcn_q;

endmodule

// ===== verif/run_list_cluster_mapper_test.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the run list cluster mapper: directed table, then random run lists
module run_list_cluster_mapper_test;
	import rlcm_pkg::*;

	localparam int ITEM_GOAL   = 1900;
	localparam int QUIET_AFTER = 1650;
	localparam int HOLD_AT     = 500;
	localparam int DRAIN_AT    = 1000;
	localparam int HOLD_CYCLES = 400;
	localparam int ROWS        = 25;

	typedef enum logic [1:0] {
		CHECK_MODEL,
		CHECK_SILENT,
		CHECK_TYPED
	} check_t;

	typedef struct packed {
		logic             rt;
		logic [63:0]      tgt;
		logic [7:0]       b;
		logic             last;
		check_t           check;
		status_t          st;
		logic [LCN_W-1:0] lcn;
	} stim_row_t;

	typedef struct packed {
		status_t          status;
		logic [LCN_W-1:0] lcn;
	} answer_t;

	logic clk;
	logic arst_n;

	rlcm_req_if req_bus ();
	rlcm_res_if res_bus ();

	run_list_cluster_mapper dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.res    (res_bus)
	);

	// walker state kept by the bench's own model of the block
	phase_t           map_phase;
	logic [3:0]       map_left;
	logic [2:0]       map_index;
	logic [3:0]       map_off_size;
	logic [LCN_W-1:0] map_count;
	logic [LCN_W-1:0] map_offset;
	logic [LCN_W-1:0] map_lcn;
	logic [LCN_W-1:0] map_remaining;

	answer_t   pending_answers[$];
	stim_row_t directed[0:ROWS-1];
	int        walked_items = 0;
	int        mismatches = 0;
	bit        quiet = 0;
	bit        hold_asked = 0;
	bit        hold_done = 0;
	bit        long_hold = 0;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// adds the signed offset of a complete run and checks the remaining vcn against its count
	function automatic logic settle_run(output answer_t ans);
		logic [LCN_W-1:0] delta;
		int               w;
		delta = map_offset;
		ans = '{ST_NOT_FOUND, {LCN_W{1'b0}}};
		if (map_off_size == 4'd0) begin
			delta = '0;
		end else if (map_off_size < MAX_FIELD_BYTES) begin
			w = int'(map_off_size) * 8;
			if (delta[w-1])
				delta = delta | ~((64'd1 << w) - 64'd1);
		end
		map_lcn = map_lcn + delta;
		if (map_remaining < map_count) begin
			ans = '{ST_FOUND, map_lcn + map_remaining};
			map_phase = PH_IDLE;
			return 1'b1;
		end
		map_remaining = map_remaining - map_count;
		map_phase = PH_HEADER;
		return 1'b0;
	endfunction

	function automatic logic walk_transfer(input stim_row_t s, output answer_t ans);
		logic [3:0]       cs;
		logic [3:0]       os;
		logic [LCN_W-1:0] wide;
		cs = s.b[3:0];
		os = s.b[7:4];
		wide = {{(LCN_W-8){1'b0}}, s.b};
		ans = '{ST_NOT_FOUND, {LCN_W{1'b0}}};
		if (s.rt == REQ_START) begin
			map_remaining = s.tgt;
			map_lcn = '0;
			map_count = '0;
			map_offset = '0;
			map_left = '0;
			map_index = '0;
			map_off_size = '0;
			map_phase = PH_HEADER;
			return 1'b0;
		end
		if (map_phase == PH_IDLE)
			return 1'b0;
		case (map_phase)
			PH_HEADER: begin
				if (s.b == 8'd0) begin
					map_phase = PH_IDLE;
					return 1'b1;
				end
				if (cs > MAX_FIELD_BYTES || os > MAX_FIELD_BYTES) begin
					ans = '{ST_MALFORMED, {LCN_W{1'b0}}};
					map_phase = PH_IDLE;
					return 1'b1;
				end
				map_off_size = os;
				map_count = '0;
				map_offset = '0;
				map_index = '0;
				if (cs != 4'd0) begin
					map_phase = PH_COUNT;
					map_left = cs;
				end else if (os != 4'd0) begin
					map_phase = PH_OFFSET;
					map_left = os;
				end else if (settle_run(ans)) begin
					return 1'b1;
				end
			end
			PH_COUNT: begin
				map_count = map_count | (wide << {map_index, 3'b000});
				map_index = map_index + 3'd1;
				map_left = map_left - 4'd1;
				if (map_left == 4'd0) begin
					map_index = '0;
					if (map_off_size != 4'd0) begin
						map_phase = PH_OFFSET;
						map_left = map_off_size;
					end else if (settle_run(ans)) begin
						return 1'b1;
					end
				end
			end
			default: begin
				map_offset = map_offset | (wide << {map_index, 3'b000});
				map_index = map_index + 3'd1;
				map_left = map_left - 4'd1;
				if (map_left == 4'd0) begin
					map_index = '0;
					if (settle_run(ans))
						return 1'b1;
				end
			end
		endcase
		if (s.last && map_phase != PH_IDLE) begin
			ans = '{ST_NOT_FOUND, {LCN_W{1'b0}}};
			map_phase = PH_IDLE;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic stim_row_t model_row(input logic rt, input logic [63:0] tgt,
		input logic [7:0] b, input logic last);
		return '{rt, tgt, b, last, CHECK_MODEL, ST_FOUND, {LCN_W{1'b0}}};
	endfunction

	task automatic send_item(input stim_row_t s);
		answer_t ans;
		logic    hit;
		req_bus.valid      <= 1'b1;
		req_bus.req_type   <= s.rt;
		req_bus.target_vcn <= s.tgt;
		req_bus.run_byte   <= s.b;
		req_bus.last_byte  <= s.last;
		do @(posedge clk); while (!req_bus.ready);
		if (!(s.rt == REQ_BYTE && map_phase == PH_IDLE))
			walked_items++;
		hit = walk_transfer(s, ans);
		case (s.check)
			CHECK_MODEL: begin
				if (hit)
					pending_answers.push_back(ans);
			end
			CHECK_TYPED: begin
				pending_answers.push_back('{s.st, s.lcn});
			end
			default: begin
			end
		endcase
		@(negedge clk);
		if (!quiet && !long_hold && $urandom_range(0, 9) == 0) begin
			req_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
	endtask

	always @(posedge clk) begin
		answer_t exp_ans;
		if (arst_n && res_bus.valid && res_bus.ready) begin
			if (pending_answers.size() == 0) begin
				mismatches++;
				$display("%0t: expected no transfer, got status %0d lcn %h",
					$time, res_bus.status, res_bus.lcn);
			end else begin
				exp_ans = pending_answers.pop_front();
				if (res_bus.status !== exp_ans.status || res_bus.lcn !== exp_ans.lcn) begin
					mismatches++;
					$display("%0t: expected status %0d lcn %h, got status %0d lcn %h",
						$time, exp_ans.status, exp_ans.lcn, res_bus.status, res_bus.lcn);
				end
			end
		end
	end

	initial begin
		res_bus.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_asked && !hold_done) begin
				hold_done = 1'b1;
				long_hold = 1'b1;
				res_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				long_hold = 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				res_bus.ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(negedge clk);
			end else begin
				res_bus.ready <= 1'b1;
				@(negedge clk);
			end
		end
	end

	initial begin
		int          i;
		int          r;
		int          j;
		int          runs;
		int          nbytes;
		int          flaw;
		int          cut_at;
		bit          drained;
		logic [3:0]  cs;
		logic [3:0]  os;
		logic [7:0]  v;
		logic [63:0] target;
		logic        small_counts;
		logic        final_run;

		drained = 1'b0;
		arst_n = 1'b0;
		req_bus.valid = 1'b0;
		req_bus.req_type = REQ_START;
		req_bus.target_vcn = '0;
		req_bus.run_byte = '0;
		req_bus.last_byte = 1'b0;
		map_phase = PH_IDLE;
		map_left = '0;
		map_index = '0;
		map_off_size = '0;
		map_count = '0;
		map_offset = '0;
		map_lcn = '0;
		map_remaining = '0;

		directed = '{
			'{REQ_BYTE,  64'd0, 8'h11, 1'b1, CHECK_SILENT, ST_FOUND, 64'd0},
			'{REQ_START, 64'd0, 8'h00, 1'b0, CHECK_MODEL, ST_FOUND, 64'd0},
			'{REQ_BYTE,  64'd0, 8'h00, 1'b0, CHECK_TYPED, ST_NOT_FOUND, 64'd0},
			'{REQ_START, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 1'b1, CHECK_MODEL, ST_FOUND, 64'd0},
			'{REQ_BYTE,  64'd0, 8'h19, 1'b0, CHECK_TYPED, ST_MALFORMED, 64'd0},
			'{REQ_START, 64'd5, 8'h00, 1'b0, CHECK_MODEL, ST_FOUND, 64'd0},
			'{REQ_BYTE,  64'd0, 8'h91, 1'b0, CHECK_TYPED, ST_MALFORMED, 64'd0},
			'{REQ_START, 64'd5, 8'h00, 1'b0, CHECK_MODEL, ST_FOUND, 64'd0},
			'{REQ_BYTE,  64'd0, 8'h11, 1'b0, CHECK_MODEL, ST_FOUND, 64'd0},
			'{REQ_BYTE,  64'd0, 8'h0A, 1'b0, CHECK_MODEL, ST_FOUND, 64'd0},
			'{REQ_BYTE,  64'd0, 8'h64, 1'b0, CHECK_TYPED, ST_FOUND, 64'd105},
			'{REQ_START, 64'd3, 8'h00, 1'b0, CHECK_MODEL, ST_FOUND, 64'd0},
			'{REQ_BYTE,  64'd0, 8'h11, 1'b0, CHECK_MODEL, ST_FOUND, 64'd0},
			'{REQ_BYTE,  64'd0, 8'h02, 1'b0, CHECK_MODEL, ST_FOUND, 64'd0},
			'{REQ_BYTE,  64'd0, 8'hFF, 1'b0, CHECK_MODEL, ST_FOUND, 64'd0},
			'{REQ_BYTE,  64'd0, 8'h01, 1'b0, CHECK_MODEL, ST_FOUND, 64'd0},
			'{REQ_BYTE,  64'd0, 8'h04, 1'b1, CHECK_MODEL, ST_FOUND, 64'd0},
			'{REQ_START, 64'd7, 8'h00, 1'b0, CHECK_MODEL, ST_FOUND, 64'd0},
			'{REQ_BYTE,  64'd0, 8'h21, 1'b0, CHECK_MODEL, ST_FOUND, 64'd0},
			'{REQ_BYTE,  64'd0, 8'h05, 1'b1, CHECK_TYPED, ST_NOT_FOUND, 64'd0},
			'{REQ_START, 64'd0, 8'h00, 1'b0, CHECK_MODEL, ST_FOUND, 64'd0},
			'{REQ_BYTE,  64'd0, 8'h10, 1'b0, CHECK_MODEL, ST_FOUND, 64'd0},
			'{REQ_BYTE,  64'd0, 8'h80, 1'b0, CHECK_MODEL, ST_FOUND, 64'd0},
			'{REQ_START, 64'd4, 8'h00, 1'b0, CHECK_MODEL, ST_FOUND, 64'd0},
			'{REQ_BYTE,  64'd0, 8'h00, 1'b1, CHECK_TYPED, ST_NOT_FOUND, 64'd0}
		};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (i = 0; i < ROWS; i++)
			send_item(directed[i]);

		while (walked_items < ITEM_GOAL) begin
			if (walked_items >= QUIET_AFTER)
				quiet = 1'b1;
			if (walked_items >= HOLD_AT)
				hold_asked = 1'b1;
			if (!drained && walked_items >= DRAIN_AT) begin
				drained = 1'b1;
				req_bus.valid <= 1'b0;
				while (pending_answers.size() != 0) @(negedge clk);
			end
			if ($urandom_range(0, 99) < 85) begin
				if ($urandom_range(0, 2) == 0)
					target = {$urandom, $urandom};
				else
					target = 64'($urandom_range(0, 1023));
				small_counts = (target < 64'd1024);
				send_item(model_row(REQ_START, target, 8'($urandom), 1'($urandom)));
				runs = $urandom_range(1, 6);
				for (r = 0; r < runs && map_phase != PH_IDLE; r++) begin
					cs = 4'($urandom_range(0, 8));
					os = 4'($urandom_range(0, 8));
					if (cs == 4'd0 && os == 4'd0)
						cs = 4'd1;
					flaw = $urandom_range(0, 39);
					if (flaw == 0) begin
						cs = 4'($urandom_range(9, 15));
					end else if (flaw == 1) begin
						os = 4'($urandom_range(9, 15));
					end else if (flaw == 2) begin
						cs = 4'd0;
						os = 4'd0;
					end
					final_run = (r == runs - 1);
					nbytes = int'(cs) + int'(os);
					cut_at = (flaw == 3) ? int'($urandom_range(0, nbytes - 1)) : -1;
					send_item(model_row(REQ_BYTE, {$urandom, $urandom}, {os, cs},
						(final_run && nbytes == 0) || cut_at == 0));
					for (j = 1; j <= nbytes && map_phase != PH_IDLE; j++) begin
						v = 8'($urandom);
						if (j > 1 && j <= int'(cs) && small_counts && $urandom_range(0, 3) != 0)
							v = 8'd0;
						send_item(model_row(REQ_BYTE, {$urandom, $urandom}, v,
							(final_run && j == nbytes) || j == cut_at));
					end
					if (flaw == 4 && map_phase != PH_IDLE)
						send_item(model_row(REQ_START, 64'($urandom_range(0, 1023)),
							8'($urandom), 1'($urandom)));
				end
			end else begin
				send_item(model_row($urandom_range(0, 4) == 0 ? REQ_START : REQ_BYTE,
					{$urandom, $urandom}, 8'($urandom), $urandom_range(0, 3) == 0));
			end
		end

		req_bus.valid <= 1'b0;
		while (pending_answers.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/rlcm_pkg.sv
sv/rlcm_if.sv
sv/rlcm_run_walker.sv
sv/rlcm_result_reg.sv
sv/run_list_cluster_mapper.sv
verif/run_list_cluster_mapper_test.sv
